/* design/frt_pkg.sv */
// Package for the fractional rank block: payload types, descriptor and back-end states.
package frt_pkg;

    // Default sizing, handed down from the top level
    localparam int MAX_SAMPLES_DEF = 64;
    localparam int VALUE_BITS_DEF  = 32;

    // Widest group count over the supported range of MAX_SAMPLES
    localparam int MAX_SAMPLES_HI = 1024;
    localparam int DESC_CNT_W     = $clog2(MAX_SAMPLES_HI + 1);

    // Fixed field widths of the ports
    localparam int SAMPLE_W = 32;
    localparam int RANK_W   = 8;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic                last_sample;
    } t_sample;

    typedef struct packed {
        logic [RANK_W-1:0] twice_rank;
        logic              last_rank;
        logic              overflow;
    } t_result;

    // One closed group, handed from the front end to the back end
    typedef struct packed {
        logic                  bank;
        logic [DESC_CNT_W-1:0] count;
        logic                  nonzero;
        logic                  dropped;
    } t_desc;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PIVOT,
        BK_LOAD,
        BK_SCAN,
        BK_DRAIN,
        BK_EMIT
    } t_back_state;

endpackage

/* design/frt_ram.sv */
// Generic single write port, single registered read port RAM.
module frt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/frt_fifo.sv */
// Small flop-based queue used between the front and back ends and at the output.
module frt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNTW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_rdata   = r_mem[r_rp];

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* design/frt_front.sv */
// Front end: takes samples into the current store bank and closes groups.
module frt_front import frt_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  t_sample                             i_sample,
    output logic                                o_full,
    output logic                                o_we,
    output logic [$clog2(MAX_SAMPLES):0]        o_waddr,
    output logic [VALUE_BITS-1:0]               o_wdata,
    output logic                                o_desc_push,
    output t_desc                               o_desc,
    input  logic                                i_desc_full
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);

    logic          r_bank;
    logic [CW-1:0] r_count;
    logic          r_nonzero;
    logic          r_dropped;

    logic                       w_accept, w_room;
    logic [CW-1:0]              n_count;
    logic                       n_nonzero, n_dropped;
    logic [VALUE_BITS+SAMPLE_W-1:0] w_ext;
    logic [VALUE_BITS-1:0]      w_value;

    // only the low VALUE_BITS of the sample are kept
    assign w_ext   = {{VALUE_BITS{1'b0}}, i_sample.sample_value};
    assign w_value = w_ext[VALUE_BITS-1:0];

    assign o_full   = i_desc_full;
    assign w_accept = i_push && !i_desc_full;
    assign w_room   = (r_count < CW'(MAX_SAMPLES));

    // store write
    assign o_we    = w_accept && w_room;
    assign o_waddr = {r_bank, r_count[IW-1:0]};
    assign o_wdata = w_value;

    // group state after this request
    assign n_count   = w_room ? r_count + 1'b1 : r_count;
    assign n_nonzero = r_nonzero || (w_room && (w_value != '0));
    assign n_dropped = r_dropped || !w_room;

    // close the group on its final sample
    assign o_desc_push    = w_accept && i_sample.last_sample;
    assign o_desc.bank    = r_bank;
    assign o_desc.count   = DESC_CNT_W'(n_count);
    assign o_desc.nonzero = n_nonzero;
    assign o_desc.dropped = n_dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank    <= 1'b0;
            r_count   <= '0;
            r_nonzero <= 1'b0;
            r_dropped <= 1'b0;
        end else if (w_accept) begin
            if (i_sample.last_sample) begin
                r_bank    <= ~r_bank;
                r_count   <= '0;
                r_nonzero <= 1'b0;
                r_dropped <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_nonzero <= n_nonzero;
                r_dropped <= n_dropped;
            end
        end
    end

endmodule

/* design/frt_back.sv */
// Back end: for each stored sample, sweeps the group counting greater and equal values.
module frt_back import frt_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_desc_empty,
    input  t_desc                         i_desc,
    output logic                          o_desc_pop,
    output logic [$clog2(MAX_SAMPLES):0]  o_raddr,
    input  logic [VALUE_BITS-1:0]         i_rdata,
    output logic                          o_res_push,
    output t_result                       o_res,
    input  logic                          i_res_full
);

    localparam int IW = $clog2(MAX_SAMPLES);
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int RW = CW + 2;

    t_back_state r_state, n_state;
    logic [IW-1:0]         r_i, n_i;
    logic [IW-1:0]         r_j, n_j;
    logic [VALUE_BITS-1:0] r_pivot, n_pivot;
    logic [CW-1:0]         r_gt, n_gt;
    logic [CW-1:0]         r_eq, n_eq;

    logic [CW-1:0]        w_n, w_n_last;
    logic [RW-1:0]        w_rank;
    logic [RW+RANK_W-1:0] w_rank_ext;
    logic                 w_is_gt, w_is_eq;

    assign w_n      = i_desc.count[CW-1:0];
    assign w_n_last = w_n - 1'b1;
    assign w_is_gt  = (i_rdata > r_pivot);
    assign w_is_eq  = (i_rdata == r_pivot);

    // doubled rank = 2*greater + equal + 1, masked to the port width
    assign w_rank     = {1'b0, r_gt, 1'b0} + RW'(r_eq) + 1'b1;
    assign w_rank_ext = {{RANK_W{1'b0}}, w_rank};

    assign o_res.twice_rank = i_desc.nonzero ? w_rank_ext[RANK_W-1:0] : '0;
    assign o_res.last_rank  = (CW'(r_i) == w_n_last);
    assign o_res.overflow   = i_desc.dropped;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i     <= n_i;
        r_j     <= n_j;
        r_pivot <= n_pivot;
        r_gt    <= n_gt;
        r_eq    <= n_eq;
    end

    // sequencer: read pivot, sweep the group, emit one result
    always_comb begin
        n_state    = r_state;
        n_i        = r_i;
        n_j        = r_j;
        n_pivot    = r_pivot;
        n_gt       = r_gt;
        n_eq       = r_eq;
        o_desc_pop = 1'b0;
        o_res_push = 1'b0;
        o_raddr    = {i_desc.bank, r_i};
        case (r_state)
            BK_IDLE: begin
                n_i = '0;
                if (!i_desc_empty) begin
                    n_state = BK_PIVOT;
                end
            end
            BK_PIVOT: begin
                o_raddr = {i_desc.bank, r_i};
                n_state = BK_LOAD;
            end
            BK_LOAD: begin
                n_pivot = i_rdata;
                o_raddr = {i_desc.bank, {IW{1'b0}}};
                n_j     = IW'(1);
                n_gt    = '0;
                n_eq    = '0;
                n_state = (w_n_last == '0) ? BK_DRAIN : BK_SCAN;
            end
            BK_SCAN: begin
                o_raddr = {i_desc.bank, r_j};
                n_gt    = r_gt + CW'(w_is_gt);
                n_eq    = r_eq + CW'(w_is_eq);
                n_j     = r_j + 1'b1;
                if (CW'(r_j) == w_n_last) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                n_gt    = r_gt + CW'(w_is_gt);
                n_eq    = r_eq + CW'(w_is_eq);
                n_state = BK_EMIT;
            end
            BK_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    if (CW'(r_i) == w_n_last) begin
                        o_desc_pop = 1'b1;
                        n_state    = BK_IDLE;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = BK_PIVOT;
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

endmodule

/* design/fractional_rank_with_ties_top.sv */
// Loading: one sample per cycle while the group queue has room; a group closes on its flagged
// sample (up to two groups queued). Ranking a group of n stored samples sweeps the group once
// per result through the single read port of the sample store. When the back end is free, the
// first result passes the group queue and the pivot, load, scan (n > 1), drain and emit states.
// Synchronous active-low reset empties both queues and the group counters; store is not cleared.
module fractional_rank_with_ties_top import frt_pkg::*; #(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
    parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sample i_sample,
    output logic    o_full,
    output logic    o_empty,
    input  logic    i_pop,
    output t_result o_result
);

    localparam int AW = $clog2(MAX_SAMPLES) + 1;

    logic                  w_we;
    logic [AW-1:0]         w_waddr, w_raddr;
    logic [VALUE_BITS-1:0] w_wdata, w_rdata;
    logic                  w_desc_push, w_desc_full, w_desc_pop, w_desc_empty;
    t_desc                 w_desc_in, w_desc_out;
    logic                  w_res_push, w_res_full;
    t_result               w_res;

    frt_front #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_sample   (i_sample),
        .o_full     (o_full),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_desc_push(w_desc_push),
        .o_desc     (w_desc_in),
        .i_desc_full(w_desc_full)
    );

    // two store banks: one filling while the other is ranked
    frt_ram #(
        .WIDTH(VALUE_BITS),
        .DEPTH(2 ** AW)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // closed groups waiting for the back end
    frt_fifo #(
        .WIDTH($bits(t_desc)),
        .DEPTH(2)
    ) u_desc_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_desc_push),
        .i_wdata(w_desc_in),
        .o_full (w_desc_full),
        .i_pop  (w_desc_pop),
        .o_rdata(w_desc_out),
        .o_empty(w_desc_empty)
    );

    frt_back #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_desc_empty(w_desc_empty),
        .i_desc      (w_desc_out),
        .o_desc_pop  (w_desc_pop),
        .o_raddr     (w_raddr),
        .i_rdata     (w_rdata),
        .o_res_push  (w_res_push),
        .o_res       (w_res),
        .i_res_full  (w_res_full)
    );

    // result queue towards the consumer
    frt_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(2)
    ) u_res_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_res_push),
        .i_wdata(w_res),
        .o_full (w_res_full),
        .i_pop  (i_pop),
        .o_rdata(o_result),
        .o_empty(o_empty)
    );

endmodule

/* verif/tb_fractional_rank_with_ties_top.sv */
// Self-checking testbench for the fractional rank block: directed and random groups, ranks checked in order.
`timescale 1ns / 1ps

module tb_fractional_rank_with_ties_top;
    import frt_pkg::*;

    localparam int GROUP_CAP    = MAX_SAMPLES_DEF;
    localparam int RANDOM_ITEMS = 360;
    localparam int LONG_HOLD    = 600;
    localparam int SETTLE_CYC   = 100;

    // Value mixes for the random groups
    typedef enum {
        MIX_TIES,
        MIX_WIDE,
        MIX_SPARSE,
        MIX_ZERO
    } t_mix;

    // Scoreboard: mirrors the group store and queues the expected ranks
    class rank_scoreboard;
        logic [SAMPLE_W-1:0] group_vals [GROUP_CAP];
        int unsigned         stored;
        bit                  seen_nonzero;
        bit                  lost_sample;
        t_result             expected_ranks [$];
        int unsigned         n_errors;
        int unsigned         n_checked;
        int unsigned         n_groups;
        int unsigned         samples_seen;
        int unsigned         n_lossy_groups;

        task report(input string msg);
            $display("[%0t] rank error: %s", $time, msg);
            n_errors++;
        endtask

        // Accepted request: store the sample, and on the flagged one rank the group
        function void note_sample(input t_sample s);
            int unsigned greater;
            int unsigned equal;
            int unsigned twice;
            t_result     r;
            samples_seen++;
            if (stored < GROUP_CAP) begin
                group_vals[stored] = s.sample_value;
                stored++;
                if (s.sample_value != '0)
                    seen_nonzero = 1'b1;
            end else begin
                lost_sample = 1'b1;
            end
            if (!s.last_sample)
                return;
            for (int unsigned i = 0; i < stored; i++) begin
                greater = 0;
                equal   = 0;
                for (int unsigned j = 0; j < stored; j++) begin
                    if (group_vals[j] > group_vals[i])
                        greater++;
                    else if (group_vals[j] == group_vals[i])
                        equal++;
                end
                twice = seen_nonzero ? 2 * greater + equal + 1 : 0;
                r.twice_rank = twice[RANK_W-1:0];
                r.last_rank  = (i + 1 == stored);
                r.overflow   = lost_sample;
                expected_ranks.insert(expected_ranks.size(), r);
            end
            n_groups++;
            if (lost_sample)
                n_lossy_groups++;
            stored       = 0;
            seen_nonzero = 1'b0;
            lost_sample  = 1'b0;
        endfunction

        // Accepted result: compare with the oldest expected rank
        task check_result(input t_result got);
            t_result want;
            if (expected_ranks.size() == 0) begin
                report($sformatf("unexpected rank %0d last %0b ovf %0b",
                                 got.twice_rank, got.last_rank, got.overflow));
                return;
            end
            want = expected_ranks.pop_front();
            n_checked++;
            if (got.twice_rank != want.twice_rank || got.last_rank != want.last_rank ||
                got.overflow != want.overflow)
                report($sformatf("rank %0d/%0d last %0b/%0b ovf %0b/%0b (got/want)",
                                 got.twice_rank, want.twice_rank, got.last_rank,
                                 want.last_rank, got.overflow, want.overflow));
        endtask
    endclass

    logic    i_clk    = 1'b0;
    logic    i_rst_n  = 1'b0;
    logic    i_push   = 1'b0;
    t_sample i_sample = '0;
    logic    i_pop    = 1'b0;
    logic    o_full;
    logic    o_empty;
    t_result o_result;

    rank_scoreboard sb;
    int unsigned    full_stalls;
    bit             send_calm;

    fractional_rank_with_ties_top u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_sample (i_sample),
        .o_full   (o_full),
        .o_empty  (o_empty),
        .i_pop    (i_pop),
        .o_result (o_result)
    );

    always #4 i_clk = ~i_clk;

    // Idle length: mostly none or short, now and then long
    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_value(input t_mix mix);
        case (mix)
            MIX_ZERO:   return '0;
            MIX_WIDE:   return $urandom;
            MIX_SPARSE: return ($urandom_range(0, 4) == 0) ? $urandom : '0;
            default: begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return 32'd1;
                    2:       return 32'hFFFF_FFFF;
                    3:       return 32'h8000_0000;
                    4:       return $urandom;
                    default: return $urandom_range(2, 5);
                endcase
            end
        endcase
    endfunction

    // One request: optional idle cycles, then hold push until accepted
    task automatic send_sample(input logic [SAMPLE_W-1:0] v, input logic last);
        int unsigned gap;
        t_sample     s;
        gap = send_calm ? 0 : idle_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s.sample_value = v;
        s.last_sample  = last;
        i_push   <= 1'b1;
        i_sample <= s;
        forever begin
            @(posedge i_clk);
            if (!o_full)
                break;
            full_stalls++;
        end
        sb.note_sample(s);
    endtask

    task automatic send_values(input logic [SAMPLE_W-1:0] vals [$]);
        for (int unsigned k = 0; k < vals.size(); k++)
            send_sample(vals[k], k + 1 == vals.size());
    endtask

    task automatic send_group(input int unsigned n, input t_mix mix);
        for (int unsigned k = 0; k < n; k++)
            send_sample(pick_value(mix), k + 1 == n);
    endtask

    // Sender stops offering until every expected rank has come out
    task automatic wait_drained();
        i_push <= 1'b0;
        while (sb.expected_ranks.size() != 0)
            @(posedge i_clk);
    endtask

    // Stimulus and end of run
    initial begin
        int unsigned sent;
        int unsigned n;
        int unsigned grp;
        t_mix        mix;
        sb          = new();
        full_stalls = 0;
        send_calm   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lone zero, lone maximum, all-zero group, ties, extremes, bit patterns
        send_values('{32'd0});
        send_values('{32'hFFFF_FFFF});
        send_values('{32'd0, 32'd0, 32'd0});
        send_values('{32'd5, 32'd5, 32'd5});
        send_values('{32'hFFFF_FFFF, 32'd0, 32'd7, 32'd7, 32'h8000_0000, 32'd1});
        send_values('{32'd0, 32'd0, 32'd9});
        send_values('{32'd1, 32'd2, 32'd3, 32'd4});
        send_values('{32'hAAAA_AAAA, 32'h5555_5555});
        wait_drained();

        // Random groups: mostly small, a few near, at or past capacity
        sent = 0;
        grp  = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 99))
                0, 1, 2, 3, 4, 5, 6, 7, 8, 9: mix = MIX_ZERO;
                10, 11, 12, 13, 14, 15, 16, 17, 18, 19,
                20, 21, 22, 23, 24, 25, 26, 27, 28, 29: mix = MIX_SPARSE;
                30, 31, 32, 33, 34, 35, 36, 37, 38, 39,
                40, 41, 42, 43, 44, 45, 46, 47, 48, 49,
                50, 51, 52, 53, 54: mix = MIX_WIDE;
                default: mix = MIX_TIES;
            endcase
            if (grp == 8)
                n = GROUP_CAP + 2;
            else if (grp == 25)
                n = GROUP_CAP;
            else if (grp == 40)
                n = GROUP_CAP + 1;
            else if ($urandom_range(0, 49) == 0)
                n = $urandom_range(GROUP_CAP - 2, GROUP_CAP + 3);
            else if ($urandom_range(0, 9) < 7)
                n = $urandom_range(1, 6);
            else
                n = $urandom_range(7, 20);
            send_calm = ($urandom_range(0, 3) == 0);
            send_group(n, mix);
            sent += n;
            grp++;
            if (grp == 60)
                wait_drained();
        end

        wait_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);
        $display("Covered %0d groups, %0d samples, %0d with dropped samples; %0d ranks compared.",
                 sb.n_groups, sb.samples_seen, sb.n_lossy_groups, sb.n_checked);
        $display("Input held off by a full block on %0d cycles.", full_stalls);
        if (sb.n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Receiver: random pop gaps, one long hold while the sender keeps going
    initial begin
        int unsigned gap;
        int unsigned taken;
        bit          held;
        bit          calm;
        taken = 0;
        held  = 1'b0;
        calm  = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        i_pop <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                taken++;
                if (taken % 40 == 0)
                    calm = ($urandom_range(0, 3) == 0);
                if (!held && taken >= 80) begin
                    held = 1'b1;
                    gap  = LONG_HOLD;
                end else begin
                    gap = calm ? 0 : idle_gap();
                end
                if (gap > 0) begin
                    i_pop <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_pop <= 1'b1;
                end
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && i_pop && !o_empty)
            sb.check_result(o_result);
    end

    // Run limit
    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
